/* rtl/fau_pkg.sv */
// Shared types and constants for the fraction arithmetic unit.
// No dependencies; imported by every module of the block.
package fau_pkg;

  // Command codes carried in the low bits of the input beat.
  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_DIV    = 3'd3,
    CMD_CMP    = 3'd4,
    CMD_REDCHK = 3'd5,
    CMD_SIGN   = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ZERODEN = 2'd1;
  localparam logic [1:0] STAT_DIVZERO = 2'd2;

  // Compare outcomes.
  localparam logic [1:0] ORD_EQ   = 2'd0;
  localparam logic [1:0] ORD_GT   = 2'd1;
  localparam logic [1:0] ORD_LT   = 2'd2;

  // Result field widths and packed output width.
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int OUT_W     = 72;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_G_CHK,
    S_G_LCD,
    S_D_Q1,
    S_D_Q2,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_CMP,
    S_RED,
    S_G_RED,
    S_D_NUM,
    S_D_DEN,
    S_OUT
  } state_t;

endpackage

/* rtl/fau_gcd.sv */
// Iterative binary GCD: one compare, subtract and shift per cycle.
// Depends on fau_pkg only for house consistency; no submodules.
module fau_gcd import fau_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] x_in,
  input  logic [DW-1:0] y_in,
  output logic          done,
  output logic [DW-1:0] result
);

  localparam int KW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [DW-1:0] x_r;
  logic [DW-1:0] y_r;
  logic [KW-1:0] k_r;
  logic [DW-1:0] res_r;

  // Subtract-and-halve step; an odd minus an odd is always even.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // Done pulses for a trivial start or when the working value reaches zero.
      done_r <= start ? ((x_in == '0) || (y_in == '0)) : (busy_r && (x_r == '0));
      if (start) begin
        if (y_in == '0) begin
          res_r  <= x_in;
        end else if (x_in == '0) begin
          res_r  <= y_in;
        end else begin
          x_r    <= x_in;
          y_r    <= y_in;
          k_r    <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (x_r == '0) begin
          res_r  <= y_r << k_r;
          busy_r <= 1'b0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= (x_r - y_r) >> 1;
        end else begin
          y_r <= (y_r - x_r) >> 1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

/* rtl/fau_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on fau_pkg; no submodules.
module fau_div import fau_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   sh;

  assign sh = {rem_r[DW-1:0], quo_r[DW-1]};

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(DW - 1));
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        d_r    <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (sh >= {1'b0, d_r}) begin
          rem_r <= sh - {1'b0, d_r};
          quo_r <= {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          quo_r <= {quo_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/fraction_arithmetic_unit.sv */
// Fraction arithmetic unit: one item at a time through a sequencer sharing one
// multiplier, one binary GCD unit and one 2W-bit serial divider.
// Time from accept to out_tvalid depends on the command and on data-dependent GCD runs.
// A new item is taken only once the last result is loaded into the output register.
// Reset: synchronous rst_n clears state.
module fraction_arithmetic_unit import fau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // cmd, a_num, a_den, b_num, b_den from bit 0 up, zero pad to bytes
  input  logic [((3+4*OPERAND_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // res_num, res_den, order, reduced_flag, negative_flag, status from bit 0 up
  output logic [OUT_W-1:0]                       out_tdata
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int SW = MW + 2;
  localparam int XW = (MW > RES_NUM_W) ? MW : RES_NUM_W;
  localparam int PAD_W = OUT_W - RES_NUM_W - RES_DEN_W - 6;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  state_t state_r, state_nxt;

  logic          accept;
  logic [W-1:0]  f_an, f_ad, f_bn, f_bd;
  cmd_t          cmd_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r, q1_r, q2_r;
  logic          a_neg_r, b_neg_r, num_neg_r;
  logic [MW-1:0] g_r, p0_r, p1_r, t_r;
  logic [1:0]    status_r, order_r;
  logic          red_r, negf_r, arith_r;
  logic          out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic          err_den, err_div, is_addsub, disp_ok;
  logic          gcd_start, gcd_done, div_start, div_done;
  logic [MW-1:0] gcd_x, gcd_y, gcd_res, div_n, div_d, div_q;
  logic [W-1:0]  mul_a, mul_b;
  logic [MW-1:0] mul_p;
  logic signed [SW-1:0] sa, sb, ss, sl, sr;
  logic [SW-1:0] ss_abs;
  logic [XW-1:0] num_ext, num_sgn, den_ext;
  logic [RES_NUM_W-1:0] res_num_f;
  logic [RES_DEN_W-1:0] res_den_f;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Operand fields as they arrive.
  assign f_an = in_tdata[3+W-1:3];
  assign f_ad = in_tdata[3+2*W-1:3+W];
  assign f_bn = in_tdata[3+3*W-1:3+2*W];
  assign f_bd = in_tdata[3+4*W-1:3+3*W];

  // Error and command decode.
  assign err_den   = (ad_r == '0) || ((cmd_r <= CMD_CMP) && (bd_r == '0));
  assign err_div   = (cmd_r == CMD_DIV) && (bn_r == '0);
  assign is_addsub = (cmd_r == CMD_ADD) || (cmd_r == CMD_SUB);
  assign disp_ok   = (cmd_r != CMD_NONE) && !err_den && !err_div;

  // Shared multiplier with registered product.
  always_comb begin
    mul_a = an_r;
    mul_b = bn_r;
    unique case (state_r)
      S_MUL0: begin
        mul_a = an_r;
        mul_b = (cmd_r == CMD_MUL) ? bn_r : (is_addsub ? q1_r : bd_r);
      end
      S_MUL1: begin
        mul_a = ad_r;
        mul_b = (cmd_r == CMD_MUL) ? bd_r : (is_addsub ? q1_r : bn_r);
      end
      S_MUL2: begin
        mul_a = bn_r;
        mul_b = q2_r;
      end
      default: begin
        mul_a = an_r;
        mul_b = bn_r;
      end
    endcase
  end
  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // Signed sum for add and subtract, signed values for compare.
  assign sa = a_neg_r ? -$signed({2'b00, p0_r}) : $signed({2'b00, p0_r});
  assign sb = (b_neg_r ^ (cmd_r == CMD_SUB)) ? -$signed({2'b00, t_r})
                                              : $signed({2'b00, t_r});
  assign ss = sa + sb;
  assign ss_abs = ss[SW-1] ? SW'(-ss) : SW'(ss);
  assign sl = sa;
  assign sr = b_neg_r ? -$signed({2'b00, p1_r}) : $signed({2'b00, p1_r});

  // Next state and unit starts.
  always_comb begin
    state_nxt = state_r;
    gcd_start = 1'b0;
    gcd_x     = '0;
    gcd_y     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_DISP;
      S_DISP: begin
        if (cmd_r == CMD_NONE || err_den || err_div || cmd_r == CMD_SIGN) begin
          state_nxt = S_OUT;
        end else if (cmd_r == CMD_REDCHK) begin
          gcd_start = 1'b1;
          gcd_x     = MW'(an_r);
          gcd_y     = MW'(ad_r);
          state_nxt = S_G_CHK;
        end else if (is_addsub) begin
          gcd_start = 1'b1;
          gcd_x     = MW'(ad_r);
          gcd_y     = MW'(bd_r);
          state_nxt = S_G_LCD;
        end else begin
          state_nxt = S_MUL0;
        end
      end
      S_G_CHK: if (gcd_done) state_nxt = S_OUT;
      S_G_LCD: if (gcd_done) begin
        div_start = 1'b1;
        div_n     = MW'(bd_r);
        div_d     = gcd_res;
        state_nxt = S_D_Q1;
      end
      S_D_Q1: if (div_done) begin
        div_start = 1'b1;
        div_n     = MW'(ad_r);
        div_d     = g_r;
        state_nxt = S_D_Q2;
      end
      S_D_Q2: if (div_done) state_nxt = S_MUL0;
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: begin
        if (cmd_r == CMD_CMP) state_nxt = S_CMP;
        else if (is_addsub)   state_nxt = S_MUL2;
        else                  state_nxt = S_RED;
      end
      S_MUL2: state_nxt = S_ADD;
      S_ADD:  state_nxt = S_RED;
      S_CMP:  state_nxt = S_OUT;
      S_RED: begin
        gcd_start = 1'b1;
        gcd_x     = p0_r;
        gcd_y     = p1_r;
        state_nxt = S_G_RED;
      end
      S_G_RED: if (gcd_done) begin
        div_start = 1'b1;
        div_n     = p0_r;
        div_d     = gcd_res;
        state_nxt = S_D_NUM;
      end
      S_D_NUM: if (div_done) begin
        div_start = 1'b1;
        div_n     = p1_r;
        div_d     = g_r;
        state_nxt = S_D_DEN;
      end
      S_D_DEN: if (div_done) state_nxt = S_OUT;
      S_OUT: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers loaded by the sequencer.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_tdata[2:0]);
      an_r    <= mag_of(f_an);
      ad_r    <= mag_of(f_ad);
      bn_r    <= mag_of(f_bn);
      bd_r    <= mag_of(f_bd);
      a_neg_r <= (f_an[W-1] != f_ad[W-1]) && (f_an != '0);
      b_neg_r <= (f_bn[W-1] != f_bd[W-1]) && (f_bn != '0);
    end
    unique case (state_r)
      S_DISP: begin
        // An unknown command reports nothing; errors report only the status.
        status_r  <= (cmd_r == CMD_NONE) ? STAT_OK :
                     (err_den ? STAT_ZERODEN : (err_div ? STAT_DIVZERO : STAT_OK));
        order_r   <= ORD_EQ;
        red_r     <= 1'b0;
        negf_r    <= disp_ok && (cmd_r == CMD_SIGN) && a_neg_r;
        arith_r   <= disp_ok && (cmd_r <= CMD_DIV);
        num_neg_r <= a_neg_r ^ b_neg_r;
      end
      S_G_CHK: if (gcd_done) red_r <= (gcd_res == MW'(1));
      S_G_LCD: if (gcd_done) g_r <= gcd_res;
      S_D_Q1:  if (div_done) q1_r <= div_q[W-1:0];
      S_D_Q2:  if (div_done) q2_r <= div_q[W-1:0];
      S_MUL0:  p0_r <= mul_p;
      S_MUL1:  p1_r <= mul_p;
      S_MUL2:  t_r <= mul_p;
      S_ADD: begin
        p0_r      <= ss_abs[MW-1:0];
        num_neg_r <= ss[SW-1];
      end
      S_CMP: order_r <= (sl == sr) ? ORD_EQ : ((sl > sr) ? ORD_GT : ORD_LT);
      S_G_RED: if (gcd_done) g_r <= gcd_res;
      S_D_NUM: if (div_done) p0_r <= div_q;
      S_D_DEN: if (div_done) p1_r <= div_q;
      default: ;
    endcase
  end

  // Result formatting.
  assign num_ext   = XW'(p0_r);
  assign num_sgn   = (num_neg_r && p0_r != '0) ? -num_ext : num_ext;
  assign den_ext   = XW'(p1_r);
  assign res_num_f = arith_r ? num_sgn[RES_NUM_W-1:0] : '0;
  assign res_den_f = arith_r ? den_ext[RES_DEN_W-1:0] : '0;

  // Output register decouples the result from the next item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {{PAD_W{1'b0}}, status_r, negf_r, red_r, order_r,
                        res_den_f, res_num_f};
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  fau_gcd #(.DW(MW)) u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .x_in   (gcd_x),
    .y_in   (gcd_y),
    .done   (gcd_done),
    .result (gcd_res)
  );

  fau_div #(.DW(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

/* rtl/fau_checker.sv */
// Port-level checks for the fraction arithmetic unit, bound to the top level.
// Depends on fau_pkg and on fraction_arithmetic_unit for the bind.
module fau_checker import fau_pkg::*; (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [OUT_W-1:0]                       out_tdata
);

  // An accepted beat keeps the input closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted beat");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // Error results carry no fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[69:68] != STAT_OK) |-> (out_tdata[63:0] == '0))
    else $error("error result with nonzero fraction");

  // A nonzero fraction result always has a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32:0] != '0) |-> (out_tdata[63:33] != '0))
    else $error("fraction result with zero denominator");

endmodule

bind fraction_arithmetic_unit fau_checker u_fau_checker (.*);

/* dv/fraction_arithmetic_unit_tb.sv */
// Testbench for the fraction arithmetic unit: drives operand/command beats,
// predicts each result with an in-bench rational arithmetic model and checks it.
// Depends on rtl/fau_pkg.sv and rtl/fraction_arithmetic_unit.sv.
`timescale 1ns / 100ps

module fraction_arithmetic_unit_tb;
  import fau_pkg::*;

  localparam int W      = 16;
  localparam int IN_W   = ((3 + 4 * W + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 20000;

  // Declared from the top bit down so that res_num lands in the low bits.
  typedef struct packed {
    logic [1:0]           status;
    logic                 negative_flag;
    logic                 reduced_flag;
    logic [1:0]           order;
    logic [RES_DEN_W-1:0] res_den;
    logic [RES_NUM_W-1:0] res_num;
  } fau_result_t;

  typedef struct {
    cmd_t            cmd;
    logic [W-1:0]    a_num;
    logic [W-1:0]    a_den;
    logic [W-1:0]    b_num;
    logic [W-1:0]    b_den;
    bit              has_expect;
    fau_result_t     expect_res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  fau_result_t expected_results[$];
  int  mismatch_count;
  bit  failed;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;

  fraction_arithmetic_unit #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Euclid on unsigned magnitudes.
  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Builds a reduced fraction result from a signed numerator and positive denominator.
  function automatic fau_result_t reduce_fraction(longint signed n, longint unsigned d);
    fau_result_t r;
    longint unsigned mag;
    longint unsigned g;
    r = '0;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    g = gcd_of(mag, d);
    if (g == 0) g = 1;
    mag = mag / g;
    d = d / g;
    r.res_num = (n < 0) ? RES_NUM_W'(-longint'(mag)) : RES_NUM_W'(mag);
    r.res_den = RES_DEN_W'(d);
    return r;
  endfunction

  // Predicts the result of one input beat.
  function automatic fau_result_t predict_fraction(cmd_t cmd, logic [W-1:0] an_raw,
      logic [W-1:0] ad_raw, logic [W-1:0] bn_raw, logic [W-1:0] bd_raw);
    fau_result_t r;
    longint signed an, ad, bn, bd, na, nb;
    longint unsigned da, db, g, lcd;
    r = '0;
    an = longint'($signed(an_raw));
    ad = longint'($signed(ad_raw));
    bn = longint'($signed(bn_raw));
    bd = longint'($signed(bd_raw));
    if (cmd == CMD_NONE) return r;
    if (ad == 0 || (cmd <= CMD_CMP && bd == 0)) begin
      r.status = STAT_ZERODEN;
      return r;
    end
    // Move signs onto the numerators.
    na = (ad < 0) ? -an : an;
    nb = (bd < 0) ? -bn : bn;
    da = (ad < 0) ? -ad : ad;
    db = (bd < 0) ? -bd : bd;
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        g = gcd_of(da, db);
        lcd = (da / g) * db;
        if (cmd == CMD_SUB) nb = -nb;
        r = reduce_fraction(na * longint'(lcd / da) + nb * longint'(lcd / db), lcd);
      end
      CMD_MUL: r = reduce_fraction(na * nb, da * db);
      CMD_DIV: begin
        if (nb == 0) r.status = STAT_DIVZERO;
        else if (nb < 0) r = reduce_fraction(-na * longint'(db), da * longint'(-nb));
        else r = reduce_fraction(na * longint'(db), da * longint'(nb));
      end
      CMD_CMP: begin
        if (na * longint'(db) == nb * longint'(da)) r.order = ORD_EQ;
        else if (na * longint'(db) > nb * longint'(da)) r.order = ORD_GT;
        else r.order = ORD_LT;
      end
      CMD_REDCHK: begin
        r.reduced_flag = (gcd_of((an < 0) ? -an : an, da) == 1);
      end
      default: r.negative_flag = (na < 0);
    endcase
    return r;
  endfunction

  // Sends one beat, with random idle time before it, and queues the expectation.
  task automatic send_beat(cmd_t cmd, logic [W-1:0] an, logic [W-1:0] ad,
      logic [W-1:0] bn, logic [W-1:0] bd, bit has_expect, fau_result_t typed);
    fau_result_t predicted;
    predicted = predict_fraction(cmd, an, ad, bn, bd);
    if (has_expect && predicted !== typed) begin
      $display("Directed row disagrees with prediction: typed %h predicted %h",
               typed, predicted);
      failed = 1'b1;
    end
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= IN_W'({bd, bn, ad, an, cmd});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(has_expect ? typed : predicted);
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(5, 0))
      0: return W'($urandom_range(7, 0));
      1: return -W'($urandom_range(7, 1));
      2: return {1'b1, {(W-1){1'b0}}};
      3: return {1'b0, {(W-1){1'b1}}};
      default: return W'($urandom);
    endcase
  endfunction

  function automatic fau_result_t mk_status(logic [1:0] st);
    fau_result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // Result check on each accepted output beat.
  always @(posedge clk) begin
    fau_result_t got;
    fau_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(fau_result_t)-1:0];
      if (expected_results.size() == 0) begin
        failed = 1'b1;
        if (mismatch_count < 10) $display("Unexpected result beat %h", got);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          if (mismatch_count < 10)
            $display("Mismatch: num %h/%h den %h/%h ord %h/%h red %b/%b neg %b/%b st %h/%h",
                     want.res_num, got.res_num, want.res_den, got.res_den,
                     want.order, got.order, want.reduced_flag, got.reduced_flag,
                     want.negative_flag, got.negative_flag, want.status, got.status);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fraction_arithmetic_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    fau_result_t zr;
    int phase;
    int k;
    int drain;
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatch_count = 0;
    failed = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 17;
    recv_idle_pct = 81;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: zero denominators, divide by zero, unknown command typed in; the other rows are predicted.
    zr = '0;
    rows = '{
      '{CMD_ADD, 16'd1, 16'd0, 16'd1, 16'd2, 1'b1, mk_status(STAT_ZERODEN)},
      '{CMD_CMP, 16'd1, 16'd3, 16'd1, 16'd0, 1'b1, mk_status(STAT_ZERODEN)},
      '{CMD_SIGN, 16'd5, 16'd0, 16'd1, 16'd1, 1'b1, mk_status(STAT_ZERODEN)},
      '{CMD_DIV, 16'd3, 16'd4, 16'd0, 16'd7, 1'b1, mk_status(STAT_DIVZERO)},
      '{CMD_NONE, MAXV, MINV, MAXV, MINV, 1'b1, zr},
      '{CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 1'b0, zr},
      '{CMD_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1'b0, zr},
      '{CMD_SUB, MINV, 16'd1, MAXV, 16'd1, 1'b0, zr},
      '{CMD_ADD, MAXV, MINV, MINV, MAXV, 1'b0, zr},
      '{CMD_MUL, MINV, 16'd1, MINV, 16'd1, 1'b0, zr},
      '{CMD_MUL, MAXV, MINV, 16'd3, -16'sd6, 1'b0, zr},
      '{CMD_DIV, MINV, MAXV, MAXV, MINV, 1'b0, zr},
      '{CMD_DIV, -16'sd2, 16'd4, 16'd3, -16'sd9, 1'b0, zr},
      '{CMD_CMP, 16'd1, 16'd2, 16'd2, 16'd4, 1'b0, zr},
      '{CMD_CMP, -16'sd1, 16'd2, 16'd1, -16'sd3, 1'b0, zr},
      '{CMD_CMP, MINV, 16'd1, MAXV, 16'd1, 1'b0, zr},
      '{CMD_REDCHK, 16'd0, 16'd1, 16'd0, 16'd0, 1'b0, zr},
      '{CMD_REDCHK, 16'd0, -16'sd1, 16'd0, 16'd0, 1'b0, zr},
      '{CMD_REDCHK, 16'd0, 16'd5, 16'd0, 16'd0, 1'b0, zr},
      '{CMD_REDCHK, -16'sd6, 16'd9, 16'd0, 16'd0, 1'b0, zr},
      '{CMD_REDCHK, MINV, MAXV, 16'd0, 16'd0, 1'b0, zr},
      '{CMD_SIGN, 16'd0, -16'sd3, 16'd0, 16'd0, 1'b0, zr},
      '{CMD_SIGN, -16'sd2, -16'sd3, 16'd0, 16'd0, 1'b0, zr},
      '{CMD_SIGN, 16'd2, -16'sd3, 16'd0, 16'd0, 1'b0, zr}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.cmd, row.a_num, row.a_den, row.b_num, row.b_den,
                row.has_expect, row.expect_res);
    end

    // Random part in three idling phases.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 17 : 0;
      for (k = 0; k < 430; k++)
        send_beat(cmd_t'($urandom_range(7, 0)), rand_operand(), rand_operand(),
                  rand_operand(), rand_operand(), 1'b0, zr);
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then allow for a few spare cycles.
    drain = 0;
    while (expected_results.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("fraction_arithmetic_unit_tb OK");
    end else begin
      $display("fraction_arithmetic_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
